// File: rtl/hdlcnrz_pkg.sv
// Shared types and constants of the HDLC NRZI bit-stuffing encoder.
package hdlcnrz_pkg;

    localparam logic [7:0] FLAG_BYTE   = 8'h7E;
    localparam logic [2:0] STUFF_RUN   = 3'd5;
    localparam logic [2:0] ONES_MAX    = 3'd7;
    localparam logic [3:0] BYTE_BITS   = 4'd8;
    localparam logic [7:0] MARK_RESET  = 8'd208;
    localparam logic [7:0] SPACE_RESET = 8'd113;

    localparam logic CFG_MARK  = 1'b0;
    localparam logic CFG_SPACE = 1'b1;

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic       push_dropped;
        logic       bit_sent;
        logic       tone_is_space;
        logic [7:0] tone_period;
    } t_result;

endpackage

// File: rtl/hdlc_nrzi_bit_stuffing_encoder.sv
// Top level of the HDLC NRZI bit-stuffing encoder.
//
// Input channel s_axis: tuser is the command (0 push a byte, 1 one bit-period
// tick), tdata carries the byte to push. Output channel m_axis: one item per
// input item, carrying the tone compare value, the tone, bit-sent and
// push-dropped flags. Configuration: i_cfg_we writes i_cfg_data into the mark
// period (index 0) or space period (index 1) at the same clock edge.
// Items pass a front register, a two-entry queue and the executing back stage
// with its result register; one item per cycle is sustained while
// m_axis_tready stays high; the ring buffer store is a memory whose head byte
// is prefetched into a register between byte loads.
// Reset clears the pointers, bit state and tone (mark) and loads the default
// periods; the store itself is not cleared. When the receiver holds
// m_axis_tready low the result register, queue and front register fill in
// turn, and s_axis_tready falls once all are full.
module hdlc_nrzi_bit_stuffing_encoder #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] push_byte
    input  logic        s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] tone_period, [8] tone_is_space,
                                        // [9] bit_sent, [10] push_dropped
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import hdlcnrz_pkg::*;

    logic [7:0] r_mark_period;
    logic [7:0] r_space_period;
    logic       f_vld, f_rdy;
    t_item      f_item;
    logic       q_vld, q_rdy;
    t_item      q_item;
    t_result    res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark_period  <= MARK_RESET;
            r_space_period <= SPACE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MARK:  r_mark_period  <= i_cfg_data;
                CFG_SPACE: r_space_period <= i_cfg_data;
                default:   r_mark_period  <= r_mark_period;
            endcase
        end
    end

    hdlcnrz_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_cmd      (s_axis_tuser),
        .i_data     (s_axis_tdata),
        .o_item_vld (f_vld),
        .i_item_rdy (f_rdy),
        .o_item     (f_item)
    );

    hdlcnrz_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_vld  (f_vld),
        .o_push_rdy  (f_rdy),
        .i_push_item (f_item),
        .o_pop_vld   (q_vld),
        .i_pop_rdy   (q_rdy),
        .o_pop_item  (q_item)
    );

    hdlcnrz_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_vld     (q_vld),
        .o_item_rdy     (q_rdy),
        .i_item         (q_item),
        .i_mark_period  (r_mark_period),
        .i_space_period (r_space_period),
        .o_res_vld      (m_axis_tvalid),
        .i_res_rdy      (m_axis_tready),
        .o_res          (res)
    );

    assign m_axis_tdata = {5'b0, res};

endmodule

// File: rtl/hdlcnrz_front.sv
// Front stage: accepts input items, classifies them and registers them.
module hdlcnrz_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_cmd,
    input  logic [7:0]          i_data,
    output logic                o_item_vld,
    input  logic                i_item_rdy,
    output hdlcnrz_pkg::t_item  o_item
);
    import hdlcnrz_pkg::*;

    logic  r_vld;
    t_item r_item;
    t_item n_item;

    assign o_ready    = !r_vld || i_item_rdy;
    assign o_item_vld = r_vld;
    assign o_item     = r_item;

    always_comb begin
        n_item.kind = i_cmd ? KIND_TICK : KIND_PUSH;
        n_item.data = i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// File: rtl/hdlcnrz_queue.sv
// Two-entry item queue between the front and back stages.
module hdlcnrz_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_vld,
    output logic                o_push_rdy,
    input  hdlcnrz_pkg::t_item  i_push_item,
    output logic                o_pop_vld,
    input  logic                i_pop_rdy,
    output hdlcnrz_pkg::t_item  o_pop_item
);
    import hdlcnrz_pkg::*;

    localparam int QD = 2;
    localparam int QW = $clog2(QD);

    t_item           r_slot [QD];
    logic [QW-1:0]   r_wr;
    logic [QW-1:0]   r_rd;
    logic [QW:0]     r_cnt;
    logic            push;
    logic            pop;

    assign o_push_rdy = r_cnt != (QW+1)'(QD);
    assign o_pop_vld  = r_cnt != '0;
    assign o_pop_item = r_slot[r_rd];
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = o_pop_vld && i_pop_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= i_push_item;
        end
    end

endmodule

// File: rtl/hdlcnrz_back.sv
// Back stage: byte ring buffer, bit stuffing, NRZI tone state and result register.
module hdlcnrz_back #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_item_vld,
    output logic                  o_item_rdy,
    input  hdlcnrz_pkg::t_item    i_item,
    input  logic [7:0]            i_mark_period,
    input  logic [7:0]            i_space_period,
    output logic                  o_res_vld,
    input  logic                  i_res_rdy,
    output hdlcnrz_pkg::t_result  o_res
);
    import hdlcnrz_pkg::*;

    localparam int              PW   = $clog2(BUFFER_DEPTH);
    localparam logic [PW-1:0]   LAST = PW'(BUFFER_DEPTH - 1);

    function automatic logic [PW-1:0] next_idx(input logic [PW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    logic [7:0]    r_mem [BUFFER_DEPTH];
    logic [7:0]    r_rdata;
    logic [PW-1:0] r_rd,   n_rd;
    logic [PW-1:0] r_wr,   n_wr;
    logic [7:0]    r_head, n_head;
    logic          r_head_vld, n_head_vld;
    logic          r_pend, n_pend;
    logic [7:0]    r_shift, n_shift;
    logic [3:0]    r_bits, n_bits;
    logic [2:0]    r_ones, n_ones;
    logic          r_tone, n_tone;
    logic          r_flag, n_flag;
    logic          r_res_vld;
    t_result       r_res, n_res;

    logic          fire;
    logic          do_write;
    logic          issue;
    logic          empty;
    logic          full;
    logic          stuff;
    logic          load;
    logic          have;
    logic [7:0]    cur;
    logic [PW-1:0] wr_nxt;

    assign o_item_rdy = !r_res_vld || i_res_rdy;
    assign fire       = i_item_vld && o_item_rdy;
    assign o_res_vld  = r_res_vld;
    assign o_res      = r_res;

    assign wr_nxt = next_idx(r_wr);
    assign empty  = r_rd == r_wr;
    assign full   = wr_nxt == r_rd;
    assign stuff  = (r_ones >= STUFF_RUN) && !r_flag;
    assign load   = (r_bits == '0) && r_head_vld;
    assign have   = (r_bits != '0) || r_head_vld;
    assign cur    = (r_bits == '0) ? r_head : r_shift;
    assign issue  = !r_head_vld && !r_pend && !empty;

    always_comb begin
        n_rd       = r_rd;
        n_wr       = r_wr;
        n_head     = r_head;
        n_head_vld = r_head_vld;
        n_pend     = r_pend;
        n_shift    = r_shift;
        n_bits     = r_bits;
        n_ones     = r_ones;
        n_tone     = r_tone;
        n_flag     = r_flag;
        do_write   = 1'b0;
        n_res.bit_sent     = 1'b0;
        n_res.push_dropped = 1'b0;

        // refill the head register from the store
        if (r_pend) begin
            n_head     = r_rdata;
            n_head_vld = 1'b1;
            n_pend     = 1'b0;
        end
        if (issue) begin
            n_pend = 1'b1;
        end

        if (fire) begin
            unique case (i_item.kind)
                KIND_PUSH: begin
                    if (full) begin
                        n_res.push_dropped = 1'b1;
                    end else begin
                        do_write = 1'b1;
                        n_wr     = wr_nxt;
                        if (empty) begin
                            n_head     = i_item.data;
                            n_head_vld = 1'b1;
                        end
                    end
                end
                KIND_TICK: begin
                    if (stuff) begin
                        n_tone         = !r_tone;
                        n_ones         = '0;
                        n_res.bit_sent = 1'b1;
                    end else if (have) begin
                        if (load) begin
                            n_rd       = next_idx(r_rd);
                            n_head_vld = 1'b0;
                            n_flag     = r_head == FLAG_BYTE;
                        end
                        n_shift = cur >> 1;
                        n_bits  = (load ? BYTE_BITS : r_bits) - 4'd1;
                        if (!cur[0]) begin
                            n_tone = !r_tone;
                            n_ones = '0;
                        end else if (r_ones != ONES_MAX) begin
                            n_ones = r_ones + 3'd1;
                        end
                        n_res.bit_sent = 1'b1;
                    end
                end
                default: begin
                    n_tone = r_tone;
                end
            endcase
        end

        n_res.tone_is_space = n_tone;
        n_res.tone_period   = n_tone ? i_space_period : i_mark_period;
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[r_wr] <= i_item.data;
        end
        if (issue) begin
            r_rdata <= r_mem[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd       <= '0;
            r_wr       <= '0;
            r_head_vld <= 1'b0;
            r_pend     <= 1'b0;
            r_shift    <= '0;
            r_bits     <= '0;
            r_ones     <= '0;
            r_tone     <= 1'b0;
            r_flag     <= 1'b0;
            r_res_vld  <= 1'b0;
        end else begin
            r_rd       <= n_rd;
            r_wr       <= n_wr;
            r_head_vld <= n_head_vld;
            r_pend     <= n_pend;
            r_shift    <= n_shift;
            r_bits     <= n_bits;
            r_ones     <= n_ones;
            r_tone     <= n_tone;
            r_flag     <= n_flag;
            if (o_item_rdy) begin
                r_res_vld <= fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        if (fire) begin
            r_res <= n_res;
        end
    end

    a_load_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_item.kind == KIND_TICK && !stuff && r_bits == '0 && !empty) |-> r_head_vld)
        else $error("byte load without a valid head byte");

    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_vld |-> !empty)
        else $error("head byte valid while the ring buffer is empty");

    a_pend_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !r_head_vld)
        else $error("prefetch in flight while head byte valid");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_res_vld)
        else $error("executed item produced no result");

endmodule

// File: sim/hdlc_nrzi_checker.sv
// Checker for the HDLC NRZI encoder: tracks the tone state of each accepted item and compares results.
`timescale 1ns / 1ps

module hdlc_nrzi_checker #(
    parameter int DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [7:0]  i_s_data,
    input  logic        i_s_user,
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [15:0] i_m_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import hdlcnrz_pkg::*;

    logic [7:0] ring_mem [DEPTH];
    int         head_idx;
    int         tail_idx;
    logic [7:0] cur_byte;
    logic [3:0] cur_left;
    logic [2:0] run_ones;
    logic       cur_space;
    logic       in_flag;
    logic [7:0] mark_cmp;
    logic [7:0] space_cmp;

    t_result    tone_results_q [$];
    int         fail_total = 0;
    int         result_idx = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = tone_results_q.size();

    task automatic report_mismatch(input string msg);
        $display("%0t ns checker: %s", $time, msg);
        fail_total++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                      result_idx, name, got, want));
        end
    endtask

    function automatic t_result encode_item(input t_kind kind, input logic [7:0] data);
        t_result r;
        logic    lsb;
        r = '0;
        if (kind == KIND_PUSH) begin
            if ((tail_idx + 1) % DEPTH == head_idx) begin
                r.push_dropped = 1'b1;
            end else begin
                ring_mem[tail_idx] = data;
                tail_idx = (tail_idx + 1) % DEPTH;
            end
        end else if (run_ones >= STUFF_RUN && !in_flag) begin
            cur_space  = ~cur_space;
            run_ones   = '0;
            r.bit_sent = 1'b1;
        end else begin
            if (cur_left == 0 && head_idx != tail_idx) begin
                cur_byte = ring_mem[head_idx];
                head_idx = (head_idx + 1) % DEPTH;
                cur_left = BYTE_BITS;
                in_flag  = (cur_byte == FLAG_BYTE);
            end
            if (cur_left != 0) begin
                lsb      = cur_byte[0];
                cur_byte = cur_byte >> 1;
                cur_left = cur_left - 1'b1;
                if (!lsb) begin
                    cur_space = ~cur_space;
                    run_ones  = '0;
                end else if (run_ones < ONES_MAX) begin
                    run_ones = run_ones + 1'b1;
                end
                r.bit_sent = 1'b1;
            end
        end
        r.tone_is_space = cur_space;
        r.tone_period   = cur_space ? space_cmp : mark_cmp;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got_r;
        t_result want_r;
        if (!i_rst_n) begin
            head_idx  = 0;
            tail_idx  = 0;
            cur_byte  = '0;
            cur_left  = '0;
            run_ones  = '0;
            cur_space = 1'b0;
            in_flag   = 1'b0;
            mark_cmp  = MARK_RESET;
            space_cmp = SPACE_RESET;
            tone_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MARK) begin
                    mark_cmp = i_cfg_data;
                end else begin
                    space_cmp = i_cfg_data;
                end
            end
            if (i_s_valid && i_s_ready) begin
                tone_results_q.push_back(encode_item(t_kind'(i_s_user), i_s_data));
            end
            if (i_m_valid && i_m_ready) begin
                if (tone_results_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none outstanding",
                                              result_idx));
                end else begin
                    want_r = tone_results_q.pop_front();
                    got_r  = t_result'(i_m_data[10:0]);
                    check_field("tone_period", got_r.tone_period, want_r.tone_period);
                    check_field("tone_is_space", got_r.tone_is_space, want_r.tone_is_space);
                    check_field("bit_sent", got_r.bit_sent, want_r.bit_sent);
                    check_field("push_dropped", got_r.push_dropped, want_r.push_dropped);
                    check_field("padding", i_m_data[15:11], 0);
                end
                result_idx++;
            end
        end
    end

endmodule

// File: sim/tb_hdlc_nrzi_bit_stuffing_encoder.sv
// Testbench top of the HDLC NRZI encoder: drives pushes, ticks and period writes, gives the verdict.
`timescale 1ns / 1ps

module tb_hdlc_nrzi_bit_stuffing_encoder;
    import hdlcnrz_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int FILL_ITEMS   = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] push_byte
    logic        s_axis_tuser;    // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // [7:0] tone_period, [8] tone_is_space,
                                  // [9] bit_sent, [10] push_dropped
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [7:0]  i_cfg_data;

    int          fail_count;
    int          pending;
    int          sent_count  = 0;
    int          cycle_count = 0;
    bit          tx_idle_on  = 1'b1;
    bit          rx_idle_on  = 1'b1;

    hdlc_nrzi_bit_stuffing_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    hdlc_nrzi_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_axis_tvalid),
        .i_s_ready    (s_axis_tready),
        .i_s_data     (s_axis_tdata),
        .i_s_user     (s_axis_tuser),
        .i_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .i_m_data     (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("hdlc_nrzi_bit_stuffing_encoder verification failed");
            $finish;
        end
    end

    task automatic send_item(input t_kind kind, input logic [7:0] data);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
    endtask

    // hold off until every result is back and the pipeline has drained
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic program_periods(input logic [7:0] mark, input logic [7:0] space);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MARK;
        i_cfg_data <= mark;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_SPACE;
        i_cfg_data <= space;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            int stall;
            stall = rx_idle_on ? $urandom_range(0, 18) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    initial begin
        int         phase;
        int         cfg_round;
        int         n;
        logic [7:0] b;
        phase         = 0;
        cfg_round     = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_PUSH;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_MARK;
        i_cfg_data    = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // idle tick, then a byte ending in five ones whose stuffed zero meets an empty buffer
        send_ticks(1);
        send_item(KIND_PUSH, 8'hF8);
        send_ticks(10);
        // flag byte suppresses stuffing, then all ones and all zeros
        send_item(KIND_PUSH, FLAG_BYTE);
        send_item(KIND_PUSH, 8'hFF);
        send_item(KIND_PUSH, 8'h00);
        send_ticks(10);

        while (sent_count < RANDOM_ITEMS - FILL_ITEMS) begin
            phase++;
            if (phase % 3 == 1) begin
                settle();
                case (cfg_round)
                    0:       program_periods(8'd1, 8'd255);
                    1:       program_periods(8'd255, 8'd1);
                    2:       program_periods(8'd255, 8'd255);
                    3:       program_periods(8'd1, 8'd1);
                    default: program_periods(8'($urandom_range(1, 255)),
                                             8'($urandom_range(1, 255)));
                endcase
                cfg_round++;
            end
            tx_idle_on = ($urandom_range(0, 2) != 0);
            rx_idle_on = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 9) < 8) begin
                n = $urandom_range(1, 10);
                send_item(KIND_PUSH, FLAG_BYTE);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 7))
                        0, 1:    b = 8'hFF;
                        2:       b = FLAG_BYTE;
                        3:       b = 8'($urandom | $urandom);
                        4:       b = 8'($urandom_range(0, 255)) | 8'hF8;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    send_item(KIND_PUSH, b);
                    send_ticks($urandom_range(0, 3));
                end
                send_item(KIND_PUSH, FLAG_BYTE);
                send_ticks((n + 2) * 10 + $urandom_range(0, 6));
            end else begin
                repeat ($urandom_range(10, 40)) begin
                    send_item(t_kind'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                end
            end
        end

        // fill the ring past full, then let ticks free single slots near the top
        tx_idle_on = 1'b0;
        rx_idle_on = ($urandom_range(0, 1) != 0);
        for (int i = 0; i < FILL_ITEMS; i++) begin
            if (i > 250 && $urandom_range(0, 3) == 0) begin
                send_ticks(1);
            end else begin
                send_item(KIND_PUSH, 8'($urandom_range(0, 255)));
            end
        end

        settle();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("hdlc_nrzi_bit_stuffing_encoder verification clean");
        end else begin
            $display("hdlc_nrzi_bit_stuffing_encoder verification failed");
        end
        $finish;
    end

endmodule
